// ===== rtl/ssmo_pkg.sv =====
// Package with the shared types, codes and defaults of the sorted set merge block.
`timescale 1ns / 1ps
`default_nettype none

package ssmo_pkg;

   localparam int DEF_SET_CAPACITY = 32;

   localparam logic [2:0] FUNC_ADD     = 3'd0;
   localparam logic [2:0] FUNC_REMOVE  = 3'd1;
   localparam logic [2:0] FUNC_UNION   = 3'd2;
   localparam logic [2:0] FUNC_INTER   = 3'd3;
   localparam logic [2:0] FUNC_DIFF    = 3'd4;
   localparam logic [2:0] FUNC_SYMDIFF = 3'd5;
   localparam logic [2:0] FUNC_CLEAR   = 3'd6;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_NOCHG  = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOC_RD,
      ST_LOC_CMP,
      ST_DECIDE,
      ST_SHU_RD,
      ST_SHU_WR,
      ST_SHD_RD,
      ST_SHD_WR,
      ST_CLR,
      ST_RESP,
      ST_MRG_RD,
      ST_MRG_CMP,
      ST_MRG_END
   } state_type;

   typedef enum logic [1:0] {
      OUT_STATUS,
      OUT_PEND,
      OUT_EMPTY
   } out_kind_type;

   typedef struct packed {
      logic         latch_req;
      logic         clr_i;
      logic         inc_i;
      logic         clr_j;
      logic         set_j_cnt;
      logic         set_j_pos;
      logic         inc_j;
      logic         dec_j;
      logic         rd_loc;
      logic         rd_up;
      logic         rd_dn;
      logic         rd_mrg;
      logic         wr_key;
      logic         wr_shift;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         cnt_clr;
      logic         found_ld;
      logic         found_clr;
      logic         mrg_adv;
      logic         pend_ld;
      logic         pend_clr;
      logic         out_ld;
      out_kind_type out_kind;
      logic         out_last;
      logic [1:0]   out_status;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_func;
      logic [2:0] func;
      logic       i_lt_cnt;
      logic       rd_lt_key;
      logic       found;
      logic       cnt_full;
      logic       j_gt_pos;
      logic       j1_lt_cnt;
      logic       mrg_done;
      logic       mrg_take;
      logic       pend_valid;
      logic       out_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/ssmo_if.sv =====
// Channel interfaces for the request and response items of the sorted set merge block.
`timescale 1ns / 1ps
`default_nettype none

interface ssmo_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic        target_set;
   logic signed [31:0] value;

   modport source (output valid, func, target_set, value, input ready);
   modport sink (input valid, func, target_set, value, output ready);
endinterface

interface ssmo_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] element;
   logic [1:0]  status;
   logic        is_empty;
   logic        last;

   modport source (output valid, element, status, is_empty, last, input ready);
   modport sink (input valid, element, status, is_empty, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssmo_datapath.sv =====
// Datapath with the two set memories, counters, merge compare and response register.
`timescale 1ns / 1ps
`default_nettype none

module ssmo_datapath
   import ssmo_pkg::*;
#(
   parameter int SET_CAPACITY = DEF_SET_CAPACITY
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [2:0]         req_func,
   input  wire logic               req_target_set,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_element,
   output logic [1:0]              rsp_status,
   output logic                    rsp_is_empty,
   output logic                    rsp_last,
   input  wire cmd_type            cmd,
   output stat_type                stat
);

   localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int CW = $clog2(SET_CAPACITY + 1);

   logic [31:0] mem_a [SET_CAPACITY];
   logic [31:0] mem_b [SET_CAPACITY];
   logic [31:0] rd_a_ff, rd_b_ff;

   logic [2:0]         func_ff, func_in;
   logic               target_ff, target_in;
   logic signed [31:0] value_ff, value_in;
   logic [CW-1:0]      i_ff, i_in, j_ff, j_in;
   logic [CW-1:0]      cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic               found_ff, found_in;
   logic [31:0]        pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] element_ff, element_in;
   logic [1:0]         status_ff, status_in;
   logic               is_empty_ff, is_empty_in;
   logic               last_ff, last_in;

   logic [CW-1:0] tcnt, tcnt_new, taddr;
   logic [31:0]   rd_t, wr_data;
   logic [AW-1:0] addr_a, addr_b, wr_addr;
   logic          rd_t_en, en_a, en_b, wr_en;
   logic          a_ok, b_ok, sel_a, sel_b, keep_a, keep_b, keep_both, take;
   logic [31:0]   mrg_val;
   logic          out_free;

   assign tcnt  = target_ff ? cnt_b_ff : cnt_a_ff;
   assign rd_t  = target_ff ? rd_b_ff : rd_a_ff;
   assign a_ok  = i_ff < cnt_a_ff;
   assign b_ok  = j_ff < cnt_b_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (cmd.rd_loc) begin
         taddr = i_ff;
      end else if (cmd.rd_up) begin
         taddr = j_ff - CW'(1);
      end else begin
         taddr = j_ff + CW'(1);
      end
   end

   assign rd_t_en = cmd.rd_loc || cmd.rd_up || cmd.rd_dn;
   assign en_a    = (rd_t_en && !target_ff) || (cmd.rd_mrg && a_ok);
   assign en_b    = (rd_t_en && target_ff) || (cmd.rd_mrg && b_ok);
   assign addr_a  = cmd.rd_mrg ? i_ff[AW-1:0] : taddr[AW-1:0];
   assign addr_b  = cmd.rd_mrg ? j_ff[AW-1:0] : taddr[AW-1:0];
   assign wr_en   = cmd.wr_key || cmd.wr_shift;
   assign wr_addr = cmd.wr_key ? i_ff[AW-1:0] : j_ff[AW-1:0];
   assign wr_data = cmd.wr_key ? 32'(value_ff) : rd_t;

   always_ff @(posedge clock) begin
      if (en_a) begin
         rd_a_ff <= mem_a[addr_a];
      end
      if (en_b) begin
         rd_b_ff <= mem_b[addr_b];
      end
      if (wr_en && !target_ff) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (wr_en && target_ff) begin
         mem_b[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      keep_a    = 1'b0;
      keep_b    = 1'b0;
      keep_both = 1'b0;
      unique case (func_ff)
         FUNC_UNION: begin
            keep_a    = 1'b1;
            keep_b    = 1'b1;
            keep_both = 1'b1;
         end
         FUNC_INTER: begin
            keep_both = 1'b1;
         end
         FUNC_DIFF: begin
            keep_a = 1'b1;
         end
         FUNC_SYMDIFF: begin
            keep_a = 1'b1;
            keep_b = 1'b1;
         end
         default: begin
            keep_a = 1'b0;
         end
      endcase
   end

   assign sel_a   = !b_ok || (a_ok && ($signed(rd_a_ff) < $signed(rd_b_ff)));
   assign sel_b   = !sel_a && (!a_ok || ($signed(rd_b_ff) < $signed(rd_a_ff)));
   assign take    = sel_a ? keep_a : (sel_b ? keep_b : keep_both);
   assign mrg_val = sel_b ? rd_b_ff : rd_a_ff;

   always_comb begin
      func_in   = cmd.latch_req ? req_func : func_ff;
      target_in = cmd.latch_req ? req_target_set : target_ff;
      value_in  = cmd.latch_req ? req_value : value_ff;

      i_in = i_ff;
      if (cmd.clr_i) begin
         i_in = '0;
      end else if (cmd.inc_i || (cmd.mrg_adv && !sel_b)) begin
         i_in = i_ff + CW'(1);
      end

      j_in = j_ff;
      if (cmd.clr_j) begin
         j_in = '0;
      end else if (cmd.set_j_cnt) begin
         j_in = tcnt;
      end else if (cmd.set_j_pos) begin
         j_in = i_ff;
      end else if (cmd.dec_j) begin
         j_in = j_ff - CW'(1);
      end else if (cmd.inc_j || (cmd.mrg_adv && !sel_a)) begin
         j_in = j_ff + CW'(1);
      end

      tcnt_new = tcnt;
      if (cmd.cnt_clr) begin
         tcnt_new = '0;
      end else if (cmd.cnt_inc) begin
         tcnt_new = tcnt + CW'(1);
      end else if (cmd.cnt_dec) begin
         tcnt_new = tcnt - CW'(1);
      end
      cnt_a_in = target_ff ? cnt_a_ff : tcnt_new;
      cnt_b_in = target_ff ? tcnt_new : cnt_b_ff;

      found_in = found_ff;
      if (cmd.found_clr) begin
         found_in = 1'b0;
      end else if (cmd.found_ld) begin
         found_in = ($signed(rd_t) == value_ff);
      end

      pend_in       = cmd.pend_ld ? mrg_val : pend_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.pend_clr) begin
         pend_valid_in = 1'b0;
      end else if (cmd.pend_ld) begin
         pend_valid_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      element_in   = element_ff;
      status_in    = status_ff;
      is_empty_in  = is_empty_ff;
      last_in      = last_ff;
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
         element_in   = (cmd.out_kind == OUT_PEND) ? $signed(pend_ff) : 32'sd0;
         status_in    = (cmd.out_kind == OUT_STATUS) ? cmd.out_status : STATUS_DONE;
         is_empty_in  = (cmd.out_kind == OUT_EMPTY);
         last_in      = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff     <= func_in;
      target_ff   <= target_in;
      value_ff    <= value_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      found_ff    <= found_in;
      pend_ff     <= pend_in;
      element_ff  <= element_in;
      status_ff   <= status_in;
      is_empty_ff <= is_empty_in;
      last_ff     <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_element  = element_ff;
   assign rsp_status   = status_ff;
   assign rsp_is_empty = is_empty_ff;
   assign rsp_last     = last_ff;

   always_comb begin
      stat.req_func   = req_func;
      stat.func       = func_ff;
      stat.i_lt_cnt   = i_ff < tcnt;
      stat.rd_lt_key  = $signed(rd_t) < value_ff;
      stat.found      = found_ff;
      stat.cnt_full   = tcnt >= CW'(SET_CAPACITY);
      stat.j_gt_pos   = j_ff > i_ff;
      stat.j1_lt_cnt  = ({1'b0, j_ff} + (CW + 1)'(1)) < {1'b0, tcnt};
      stat.mrg_done   = !a_ok && !b_ok;
      stat.mrg_take   = take;
      stat.pend_valid = pend_valid_ff;
      stat.out_free   = out_free;
   end

   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> out_free)
      else $error("Response register loaded while an item is still held.");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> (tcnt < CW'(SET_CAPACITY)))
      else $error("Insert into a full set.");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_clr |=> (tcnt == '0))
      else $error("Set count not zero after clear.");

endmodule

`default_nettype wire

// ===== rtl/ssmo_ctrl.sv =====
// Controller state machine that sequences search, shift, clear and merge steps.
`timescale 1ns / 1ps
`default_nettype none

module ssmo_ctrl
   import ssmo_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.out_kind   = OUT_STATUS;
      cmd.out_status = status_ff;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               unique case (stat.req_func) inside
                  FUNC_ADD, FUNC_REMOVE: begin
                     cmd.clr_i = 1'b1;
                     state_in  = ST_LOC_RD;
                  end
                  FUNC_UNION, FUNC_INTER, FUNC_DIFF, FUNC_SYMDIFF: begin
                     cmd.clr_i    = 1'b1;
                     cmd.clr_j    = 1'b1;
                     cmd.pend_clr = 1'b1;
                     state_in     = ST_MRG_RD;
                  end
                  FUNC_CLEAR: begin
                     state_in = ST_CLR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOC_RD: begin
            if (stat.i_lt_cnt) begin
               cmd.rd_loc = 1'b1;
               state_in   = ST_LOC_CMP;
            end else begin
               cmd.found_clr = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_LOC_CMP: begin
            if (stat.rd_lt_key) begin
               cmd.inc_i = 1'b1;
               state_in  = ST_LOC_RD;
            end else begin
               cmd.found_ld = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.func == FUNC_ADD) begin
               if (stat.found) begin
                  status_in = STATUS_NOCHG;
                  state_in  = ST_RESP;
               end else if (stat.cnt_full) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_RESP;
               end else begin
                  cmd.set_j_cnt = 1'b1;
                  state_in      = ST_SHU_RD;
               end
            end else begin
               if (!stat.found) begin
                  status_in = STATUS_NOCHG;
                  state_in  = ST_RESP;
               end else begin
                  cmd.set_j_pos = 1'b1;
                  state_in      = ST_SHD_RD;
               end
            end
         end
         ST_SHU_RD: begin
            if (stat.j_gt_pos) begin
               cmd.rd_up = 1'b1;
               state_in  = ST_SHU_WR;
            end else begin
               cmd.wr_key  = 1'b1;
               cmd.cnt_inc = 1'b1;
               status_in   = STATUS_DONE;
               state_in    = ST_RESP;
            end
         end
         ST_SHU_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.dec_j    = 1'b1;
            state_in     = ST_SHU_RD;
         end
         ST_SHD_RD: begin
            if (stat.j1_lt_cnt) begin
               cmd.rd_dn = 1'b1;
               state_in  = ST_SHD_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               status_in   = STATUS_DONE;
               state_in    = ST_RESP;
            end
         end
         ST_SHD_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.inc_j    = 1'b1;
            state_in     = ST_SHD_RD;
         end
         ST_CLR: begin
            cmd.cnt_clr = 1'b1;
            status_in   = STATUS_DONE;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (stat.out_free) begin
               cmd.out_ld   = 1'b1;
               cmd.out_kind = OUT_STATUS;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MRG_RD: begin
            if (stat.mrg_done) begin
               state_in = ST_MRG_END;
            end else begin
               cmd.rd_mrg = 1'b1;
               state_in   = ST_MRG_CMP;
            end
         end
         ST_MRG_CMP: begin
            if (!(stat.mrg_take && stat.pend_valid && !stat.out_free)) begin
               cmd.mrg_adv = 1'b1;
               state_in    = ST_MRG_RD;
               if (stat.mrg_take) begin
                  cmd.pend_ld = 1'b1;
                  if (stat.pend_valid) begin
                     cmd.out_ld   = 1'b1;
                     cmd.out_kind = OUT_PEND;
                  end
               end
            end
         end
         ST_MRG_END: begin
            if (stat.out_free) begin
               cmd.out_ld   = 1'b1;
               cmd.out_kind = stat.pend_valid ? OUT_PEND : OUT_EMPTY;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/sorted_set_merge_ops.sv =====
// Top level of the sorted set merge block: two sorted integer sets with add, remove and merges.
// The req channel takes one item per command: func selects add, remove, clear or one of
// four merges, target_set picks set A or B and value is the integer to add or remove.
// The rsp channel returns items with element, status, is_empty and last.
// Add, remove and clear return one item with last set. A merge returns its elements in
// ascending order, the final one with last set, or one item with is_empty set.
// Add and remove walk the target set from the start, a read and a compare per entry visited,
// then shift the entries above the position, a read and a write per entry moved. A merge
// does one memory read and one compare for each step of the walk over both sets; clear
// zeroes the set count and then returns its response.
// A new item is accepted once the previous one has finished its work, even while the
// last response still waits in the output register.
// When the receiver stalls, the response register holds and a merge waits at its next
// element. Reset empties both sets and clears any pending response; the set memories
// need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_merge_ops
   import ssmo_pkg::*;
#(
   parameter int SET_CAPACITY = DEF_SET_CAPACITY
) (
   input  wire logic clock,
   input  wire logic reset,
   ssmo_req_if.sink   req_chan,
   ssmo_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_chan.ready = req_ready;

   ssmo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ssmo_datapath #(
      .SET_CAPACITY (SET_CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_chan.func),
      .req_target_set (req_chan.target_set),
      .req_value      (req_chan.value),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_element    (rsp_chan.element),
      .rsp_status     (rsp_chan.status),
      .rsp_is_empty   (rsp_chan.is_empty),
      .rsp_last       (rsp_chan.last),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

`default_nettype wire
